/* rtl/robst_pkg.sv */
package robst_pkg;

    localparam int CB    = 21;           // component bits
    localparam int FB    = 10;           // fraction bits
    localparam int DF    = 16;           // distance fraction bits
    localparam int EW    = 2 * CB + 3;   // dot product width
    localparam int QW    = EW + DF;      // dividend / quotient width
    localparam int DW    = EW;           // divisor / remainder width
    localparam int TW    = 64;           // interval value width
    localparam int LANES = 6;            // two divisions per slab
    localparam int NFRONT = 4;
    localparam int NPOST  = 2;
    localparam int NST    = NFRONT + QW + NPOST;

    localparam logic signed [TW-1:0] T_LIM = 64'sh4000_0000_0000_0000;
    localparam logic [31:0] DIST_SAT = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [62:0] ray_origin;
        logic [62:0] ray_direction;
        logic [62:0] box_center;
        logic [62:0] box_axis_u;
        logic [62:0] box_axis_v;
        logic [62:0] box_axis_w;
        logic [62:0] box_half_lengths;
    } t_in_word;

    typedef struct packed {
        logic        hit;
        logic [31:0] hit_distance;
    } t_out_word;

    typedef struct packed {
        logic [QW-1:0] nq;   // dividend out at the top, quotient in at the bottom
        logic [DW-1:0] rem;
        logic [DW-1:0] d;
        logic          neg;
    } t_div_lane;

    typedef struct packed {
        t_div_lane [LANES-1:0] lane;
        logic      [2:0]       par;    // slab parallel to ray
        logic      [2:0]       outs;   // origin outside a parallel slab
    } t_div_word;

    function automatic logic [CB-1:0] comp(input logic [62:0] w, input int i);
        return w[i*CB +: CB];
    endfunction

endpackage

/* rtl/ray_oriented_box_slab_test.sv */
// Ray against oriented box slab test. Each input word holds a ray and a box as
// packed signed Q10.10 vectors; each output word gives hit and the entry (or,
// from inside, exit) distance as saturating unsigned Q16.16, zero on a miss.
// One word enters per cycle when not stalled, and results leave in order after
// passing four front stages (difference, products, dot sums, numerators),
// a row of 61 divider cells that each settle one quotient bit for all six slab
// distances, and two stages that order the distances, narrow the interval and
// drive the output register. Each stage holds its word independently, so
// empty stages close up under a stall and the input is stalled only when
// every stage is full.
module ray_oriented_box_slab_test
    import robst_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_word  i_word,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_word o_word
);

    logic [NST-1:0] r_vld;
    logic [NST-1:0] w_en;
    t_div_word      w_div [QW+1];

    // stage advances when empty or when its successor advances
    assign w_en[NST-1] = !r_vld[NST-1] || !i_stall;
    for (genvar s = 0; s < NST-1; s++) begin : g_en
        assign w_en[s] = !r_vld[s] || w_en[s+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) r_vld[0] <= i_valid;
            for (int s = 1; s < NST; s++) begin
                if (w_en[s]) r_vld[s] <= r_vld[s-1];
            end
        end
    end

    robst_front u_front (
        .i_clk  (i_clk),
        .i_en   (w_en[NFRONT-1:0]),
        .i_word (i_word),
        .o_div  (w_div[0])
    );

    for (genvar j = 0; j < QW; j++) begin : g_cell
        robst_div_cell u_cell (
            .i_clk (i_clk),
            .i_en  (w_en[NFRONT+j]),
            .i_div (w_div[j]),
            .o_div (w_div[j+1])
        );
    end

    robst_post u_post (
        .i_clk  (i_clk),
        .i_en   (w_en[NST-1:NFRONT+QW]),
        .i_div  (w_div[QW]),
        .o_word (o_word)
    );

    assign o_stall = !w_en[0];
    assign o_valid = r_vld[NST-1];

    // nothing comes out straight after reset
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output word valid after reset");

    // a miss always carries zero distance
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_word.hit |-> o_word.hit_distance == '0)
        else $error("miss with nonzero distance");

    // input is held off only when the whole pipe is full
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (&r_vld) && i_stall)
        else $error("input stalled with room in pipe");

    // a stalled output word leaves the pipe valid next cycle
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("output word lost under stall");

endmodule

/* rtl/robst_front.sv */
module robst_front
    import robst_pkg::*;
(
    input  logic              i_clk,
    input  logic [NFRONT-1:0] i_en,
    input  t_in_word          i_word,
    output t_div_word         o_div
);

    logic signed [CB:0]     r_p   [3];
    logic signed [CB-1:0]   r_dir [3];
    logic signed [CB-1:0]   r_ax  [3][3];
    logic [CB-1:0]          r_h0  [3];
    logic signed [2*CB:0]   r_pe  [3][3];
    logic signed [2*CB-1:0] r_pf  [3][3];
    logic [CB-1:0]          r_h1  [3];
    logic signed [EW-1:0]   r_e   [3];
    logic signed [EW-1:0]   r_f   [3];
    logic [CB+FB-1:0]       r_hq  [3];
    t_div_word              r_div;

    // stage 0: unpack, centre minus origin
    always_ff @(posedge i_clk) begin
        logic [CB-1:0] c;
        logic [CB-1:0] o;
        if (i_en[0]) begin
            for (int i = 0; i < 3; i++) begin
                c = comp(i_word.box_center, i);
                o = comp(i_word.ray_origin, i);
                r_p[i]     <= $signed({c[CB-1], c}) - $signed({o[CB-1], o});
                r_dir[i]   <= $signed(comp(i_word.ray_direction, i));
                r_ax[0][i] <= $signed(comp(i_word.box_axis_u, i));
                r_ax[1][i] <= $signed(comp(i_word.box_axis_v, i));
                r_ax[2][i] <= $signed(comp(i_word.box_axis_w, i));
                r_h0[i]    <= comp(i_word.box_half_lengths, i);
            end
        end
    end

    // stage 1: products
    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            for (int k = 0; k < 3; k++) begin
                for (int i = 0; i < 3; i++) begin
                    r_pe[k][i] <= r_ax[k][i] * r_p[i];
                    r_pf[k][i] <= r_ax[k][i] * r_dir[i];
                end
                r_h1[k] <= r_h0[k];
            end
        end
    end

    // stage 2: sums
    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            for (int k = 0; k < 3; k++) begin
                r_e[k]  <= EW'(r_pe[k][0]) + EW'(r_pe[k][1]) + EW'(r_pe[k][2]);
                r_f[k]  <= EW'(r_pf[k][0]) + EW'(r_pf[k][1]) + EW'(r_pf[k][2]);
                r_hq[k] <= {r_h1[k], {FB{1'b0}}};
            end
        end
    end

    // stage 3: numerators, magnitudes, parallel slab tests
    t_div_word n_div;
    always_comb begin
        logic signed [EW-1:0] hs;
        logic signed [EW-1:0] nm [2];
        logic [EW-1:0]        mag;
        logic [DW-1:0]        dmag;
        n_div = '0;
        for (int k = 0; k < 3; k++) begin
            hs    = EW'(r_hq[k]);
            nm[0] = r_e[k] + hs;
            nm[1] = r_e[k] - hs;
            dmag  = r_f[k][EW-1] ? DW'(-r_f[k]) : DW'(r_f[k]);
            for (int j = 0; j < 2; j++) begin
                mag = nm[j][EW-1] ? EW'(-nm[j]) : EW'(nm[j]);
                n_div.lane[2*k+j].nq  = {mag, {DF{1'b0}}};
                n_div.lane[2*k+j].rem = '0;
                n_div.lane[2*k+j].d   = dmag;
                n_div.lane[2*k+j].neg = nm[j][EW-1] ^ r_f[k][EW-1];
            end
            n_div.par[k]  = (r_f[k] == '0);
            n_div.outs[k] = (r_e[k] < -hs) || (r_e[k] > hs);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_div <= n_div;
        end
    end

    assign o_div = r_div;

endmodule

/* rtl/robst_div_cell.sv */
module robst_div_cell
    import robst_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_en,
    input  t_div_word i_div,
    output t_div_word o_div
);

    t_div_word r_div;
    t_div_word n_div;

    // one restoring quotient bit per lane
    always_comb begin
        logic [DW:0] trial;
        logic        ge;
        n_div = i_div;
        for (int l = 0; l < LANES; l++) begin
            trial = {i_div.lane[l].rem, i_div.lane[l].nq[QW-1]};
            ge    = trial >= {1'b0, i_div.lane[l].d};
            n_div.lane[l].rem = ge ? DW'(trial - {1'b0, i_div.lane[l].d})
                                   : trial[DW-1:0];
            n_div.lane[l].nq  = {i_div.lane[l].nq[QW-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div <= n_div;
        end
    end

    assign o_div = r_div;

endmodule

/* rtl/robst_post.sv */
module robst_post
    import robst_pkg::*;
(
    input  logic             i_clk,
    input  logic [NPOST-1:0] i_en,
    input  t_div_word        i_div,
    output t_out_word        o_word
);

    logic signed [TW-1:0] r_tlo [3];
    logic signed [TW-1:0] r_thi [3];
    logic [2:0]           r_par;
    logic [2:0]           r_outs;
    t_out_word            r_out;

    // signed distances, ordered per slab
    always_ff @(posedge i_clk) begin
        logic signed [TW-1:0] t [LANES];
        if (i_en[0]) begin
            for (int l = 0; l < LANES; l++) begin
                t[l] = $signed(TW'(i_div.lane[l].nq));
                if (i_div.lane[l].neg) t[l] = -t[l];
            end
            for (int k = 0; k < 3; k++) begin
                r_tlo[k] <= (t[2*k] > t[2*k+1]) ? t[2*k+1] : t[2*k];
                r_thi[k] <= (t[2*k] > t[2*k+1]) ? t[2*k] : t[2*k+1];
            end
            r_par  <= i_div.par;
            r_outs <= i_div.outs;
        end
    end

    // interval narrowing and result
    t_out_word n_out;
    always_comb begin
        logic signed [TW-1:0] lo;
        logic signed [TW-1:0] hi;
        logic signed [TW-1:0] res;
        logic                 miss;
        lo   = -T_LIM;
        hi   = T_LIM;
        miss = 1'b0;
        for (int k = 0; k < 3; k++) begin
            if (r_par[k]) begin
                miss = miss | r_outs[k];
            end else begin
                if (r_tlo[k] > lo) lo = r_tlo[k];
                if (r_thi[k] < hi) hi = r_thi[k];
                miss = miss | (lo > hi) | (hi < 0);
            end
        end
        res = (lo > 0) ? lo : hi;
        n_out.hit = !miss;
        if (miss || res < 0)                       n_out.hit_distance = '0;
        else if (res > $signed(TW'(DIST_SAT)))     n_out.hit_distance = DIST_SAT;
        else                                       n_out.hit_distance = res[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_out <= n_out;
        end
    end

    assign o_word = r_out;

endmodule

/* bench/tb.sv */
module tb;
    import robst_pkg::*;

    // Run length and the bounds that keep a broken block from hanging the run
    localparam int N_RANDOM   = 1800;
    localparam int CYCLE_CAP  = 400000;
    localparam int DRAIN_WAIT = 100;     // pipeline depth is 67, allow a margin

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_stall;
    t_in_word  i_word;
    logic      o_valid;
    logic      i_stall;
    t_out_word o_word;

    ray_oriented_box_slab_test DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_word  (i_word),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_word  (o_word)
    );

    // One row of the directed table. Where want_fixed is set the expected
    // word is typed in, otherwise it comes from the slab predictor.
    typedef struct {
        t_in_word  w;
        bit        want_fixed;
        t_out_word want;
    } t_row;

    t_out_word hit_queue[$];   // expected result words, oldest first
    int        n_err = 0;
    int        n_sent = 0;
    int        n_seen = 0;
    int        n_hits = 0;
    int        n_miss = 0;
    int        n_sat = 0;
    longint    cycle_no = 0;

    // ---------------------------------------------------------------
    // Clock and cycle limit
    // ---------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_no <= cycle_no + 1;
        if (cycle_no > CYCLE_CAP) begin
            $display("timeout after %0d cycles, %0d words still expected",
                     cycle_no, hit_queue.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Slab predictor
    // ---------------------------------------------------------------
    function automatic longint comp_s(logic [62:0] v, int i);
        logic signed [CB-1:0] s;
        s = v[i*CB +: CB];
        return longint'(s);
    endfunction

    function automatic logic [62:0] vec(int x, int y, int z);
        logic [CB-1:0] a, b, c;
        a = x[CB-1:0];
        b = y[CB-1:0];
        c = z[CB-1:0];
        return {c, b, a};
    endfunction

    // Three slabs in turn; each narrows [lo,hi]. Parallel slabs only test
    // whether the origin lies between the planes.
    function automatic t_out_word slab_predict(t_in_word w);
        longint    p[3], d[3], ax[3][3];
        longint    e, f, h, t1, t2, tmp, lo, hi, res;
        t_out_word r;
        r = '0;
        for (int i = 0; i < 3; i++) begin
            p[i] = comp_s(w.box_center, i) - comp_s(w.ray_origin, i);
            d[i] = comp_s(w.ray_direction, i);
            ax[0][i] = comp_s(w.box_axis_u, i);
            ax[1][i] = comp_s(w.box_axis_v, i);
            ax[2][i] = comp_s(w.box_axis_w, i);
        end
        lo = -T_LIM;
        hi = T_LIM;
        for (int k = 0; k < 3; k++) begin
            e = ax[k][0] * p[0] + ax[k][1] * p[1] + ax[k][2] * p[2];
            f = ax[k][0] * d[0] + ax[k][1] * d[1] + ax[k][2] * d[2];
            h = 0;
            h[CB-1:0] = w.box_half_lengths[k*CB +: CB];
            h = h <<< FB;
            if (f != 0) begin
                t1 = ((e + h) * 64'sd65536) / f;
                t2 = ((e - h) * 64'sd65536) / f;
                if (t1 > t2) begin
                    tmp = t1;
                    t1 = t2;
                    t2 = tmp;
                end
                if (t1 > lo) lo = t1;
                if (t2 < hi) hi = t2;
                if (lo > hi || hi < 0) return r;
            end else if (e < -h || e > h) begin
                return r;
            end
        end
        res = (lo > 0) ? lo : hi;
        if (res < 0) res = 0;
        if (res > 64'sh0_FFFF_FFFF) res = 64'sh0_FFFF_FFFF;
        r.hit = 1'b1;
        r.hit_distance = res[31:0];
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Random words: mostly sensible boxes near the ray so that all three
    // slabs get exercised, the rest raw noise to toggle every bit.
    // ---------------------------------------------------------------
    function automatic logic [62:0] raw63();
        return 63'({$urandom, $urandom});
    endfunction

    function automatic int srand(int span);
        return $urandom_range(0, 2 * span) - span;
    endfunction

    function automatic logic [62:0] unit_axis(int k);
        int s;
        s = $urandom_range(0, 1) ? 1024 : -1024;
        case (k)
            0: return vec(s, srand(8), srand(8));
            1: return vec(srand(8), s, srand(8));
            default: return vec(srand(8), srand(8), s);
        endcase
    endfunction

    function automatic t_in_word random_item();
        t_in_word w;
        int       kind;
        int       sc;
        kind = $urandom_range(0, 99);
        sc = ($urandom_range(0, 9) == 0) ? 200000 : 8000;
        if (kind < 20) begin
            w = {raw63(), raw63(), raw63(), raw63(), raw63(), raw63(), raw63()};
        end else begin
            w.ray_origin    = vec(srand(sc), srand(sc), srand(sc));
            w.box_center    = vec(srand(sc), srand(sc), srand(sc));
            w.ray_direction = vec(srand(1100), srand(1100), srand(1100));
            if (kind < 30) begin
                // zero some direction components to hit the parallel slab path
                w.ray_direction = vec(0, srand(1100), 0);
            end
            if (kind < 70) begin
                w.box_axis_u = unit_axis(0);
                w.box_axis_v = unit_axis(1);
                w.box_axis_w = unit_axis(2);
            end else begin
                w.box_axis_u = vec(srand(1100), srand(1100), srand(1100));
                w.box_axis_v = vec(srand(1100), srand(1100), srand(1100));
                w.box_axis_w = vec(srand(1100), srand(1100), srand(1100));
            end
            w.box_half_lengths = vec($urandom_range(0, sc), $urandom_range(0, sc),
                                     $urandom_range(0, sc));
        end
        return w;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Offer one word and hold it until it is taken
    task automatic send_word(t_in_word w, t_out_word want, int gap);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_word  <= w;
        do @(posedge i_clk); while (o_stall);
        hit_queue.push_back(want);
        n_sent++;
    endtask

    // ---------------------------------------------------------------
    // Sender: reset, directed table, then random words
    // ---------------------------------------------------------------
    initial begin
        t_row      rows[$];
        t_row      rw;
        t_in_word  w;
        t_in_word  base;
        t_out_word want;
        int        gap;

        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_word  <= '0;

        // cube of half-length 1.0, axis aligned, centre 5.0 along x
        base.ray_origin       = vec(0, 0, 0);
        base.ray_direction    = vec(1024, 0, 0);
        base.box_center       = vec(5120, 0, 0);
        base.box_axis_u       = vec(1024, 0, 0);
        base.box_axis_v       = vec(0, 1024, 0);
        base.box_axis_w       = vec(0, 0, 1024);
        base.box_half_lengths = vec(1024, 1024, 1024);

        // box ahead: entry at 4.0
        rw.w = base; rw.want_fixed = 1; rw.want = '{1'b1, 32'h0004_0000};
        rows.push_back(rw);
        // box behind the origin
        rw.w.box_center = vec(-5120, 0, 0); rw.want = '{1'b0, 32'h0};
        rows.push_back(rw);
        // origin inside: exit distance 1.0
        rw.w.box_center = vec(0, 0, 0); rw.want = '{1'b1, 32'h0001_0000};
        rows.push_back(rw);
        // ray parallel to the u slab, origin outside it
        rw.w = base; rw.w.ray_direction = vec(0, 1024, 0); rw.want = '{1'b0, 32'h0};
        rows.push_back(rw);
        // all zero: every slab parallel and containing the origin
        rw.w = '0; rw.want = '{1'b1, 32'hFFFF_FFFF};
        rows.push_back(rw);
        // tiny direction, far box: distance saturates
        rw.w = base; rw.w.ray_direction = vec(1, 0, 0);
        rw.w.box_center = vec(1000 * 1024, 0, 0); rw.want = '{1'b1, 32'hFFFF_FFFF};
        rows.push_back(rw);

        // the rest go through the predictor
        rw.want_fixed = 0; rw.want = '0;
        rw.w = base; rw.w.ray_direction = vec(-1024, 0, 0); rows.push_back(rw);
        rw.w = base; rw.w.ray_direction = vec(1024, 300, -200); rows.push_back(rw);
        rw.w = '1; rows.push_back(rw);
        rw.w = {7{vec(21'h0F_FFFF, 21'h0F_FFFF, 21'h0F_FFFF)}}; rows.push_back(rw);
        rw.w = {7{vec(21'h10_0000, 21'h10_0000, 21'h10_0000)}}; rows.push_back(rw);
        rw.w = base; rw.w.ray_origin = vec(21'h10_0000, 21'h0F_FFFF, 0);
        rw.w.box_center = vec(21'h0F_FFFF, 21'h10_0000, 0); rows.push_back(rw);
        rw.w = base; rw.w.box_half_lengths = '1; rows.push_back(rw);
        rw.w = base; rw.w.box_half_lengths = '0; rows.push_back(rw);
        // non-unit, skewed axes
        rw.w = base; rw.w.box_axis_u = vec(3000, -700, 40);
        rw.w.box_axis_v = vec(-5, 2048, 900); rw.w.box_axis_w = vec(1, 1, 1);
        rows.push_back(rw);
        // origin on the slab boundary with a parallel ray
        rw.w = base; rw.w.ray_direction = vec(0, 0, 1024);
        rw.w.box_center = vec(1024, 0, 0); rows.push_back(rw);
        rw.w.box_center = vec(1025, 0, 0); rows.push_back(rw);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[j]) begin
            want = rows[j].want_fixed ? rows[j].want : slab_predict(rows[j].w);
            send_word(rows[j].w, want, pick_gap());
        end

        for (int n = 0; n < N_RANDOM; n++) begin
            // pause the sender until the pipeline has drained completely
            if (n == 1400) begin
                i_valid <= 1'b0;
                while (hit_queue.size() != 0) @(posedge i_clk);
                repeat (DRAIN_WAIT) @(posedge i_clk);
            end
            // a stretch of back-to-back words with no gaps
            gap = (n >= 1000 && n < 1200) ? 0 : pick_gap();
            // keep offering during the long receiver hold-off so the block fills
            if (n >= 450 && n < 650) gap = 0;
            w = random_item();
            send_word(w, slab_predict(w), gap);
        end
        i_valid <= 1'b0;

        while (hit_queue.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("sent %0d words (%0d directed), checked %0d: %0d hits, %0d misses",
                 n_sent, rows.size(), n_seen, n_hits, n_miss);
        $display("saturated distances %0d, one long receiver hold-off, one full drain",
                 n_sat);
        if (n_err == 0 && hit_queue.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // ---------------------------------------------------------------
    // Receiver: checks each word taken and drives stall
    // ---------------------------------------------------------------
    task automatic report(string what, t_out_word got, t_out_word want);
        n_err++;
        $display("mismatch %s at cycle %0d: got hit=%0b dist=%h, want hit=%0b dist=%h",
                 what, cycle_no, got.hit, got.hit_distance, want.hit, want.hit_distance);
    endtask

    int  stall_left = 0;
    int  hold_left = 0;
    bit  hold_done = 0;

    always @(posedge i_clk) begin
        t_out_word want;
        int        r;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (hit_queue.size() == 0) begin
                    report("unexpected word", o_word, '0);
                end else begin
                    want = hit_queue.pop_front();
                    if (o_word.hit !== want.hit)
                        report("hit", o_word, want);
                    if (o_word.hit_distance !== want.hit_distance)
                        report("distance", o_word, want);
                end
                n_seen++;
                if (o_word.hit) n_hits++; else n_miss++;
                if (o_word.hit && o_word.hit_distance == DIST_SAT) n_sat++;
            end

            // long hold-off once, well into the random part
            if (!hold_done && n_sent >= 450) begin
                hold_done = 1;
                hold_left = 400;
            end

            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (n_sent >= 1000 && n_sent < 1200) begin
                i_stall <= 1'b0;   // quiet stretch: no stalls
            end else begin
                if (stall_left == 0) begin
                    r = $urandom_range(0, 99);
                    if (r < 65) stall_left = 0;
                    else if (r < 92) stall_left = $urandom_range(1, 3);
                    else if (r < 99) stall_left = $urandom_range(4, 12);
                    else stall_left = $urandom_range(30, 80);
                end
                if (stall_left > 0) begin
                    stall_left--;
                    i_stall <= 1'b1;
                end else begin
                    i_stall <= 1'b0;
                end
            end
        end else begin
            i_stall <= 1'b0;
        end
    end

endmodule

/* sim.f */
rtl/robst_pkg.sv
rtl/robst_front.sv
rtl/robst_div_cell.sv
rtl/robst_post.sv
rtl/ray_oriented_box_slab_test.sv
bench/tb.sv
